/* rtl/sha1_message_digest_assert.svh */
// Assertion macros for the SHA-1 message digest block.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH
`ifndef ASSERT_OFF
// Plain clocked property, disabled while reset is active.
`define SHA1MD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Overlapping implication between an antecedent and a consequent.
`define SHA1MD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SHA1MD_ASSERT(lbl, prop, msg)
`define SHA1MD_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* rtl/sha1md_pkg.sv */
// Shared types, constants and helper functions of the SHA-1 message digest block.
// Depends on nothing; used by all modules in this folder.
`timescale 1ns / 1ps
package sha1md_pkg;

  // Five 32-bit words: chaining values or working variables, index 0 is H0 / a.
  typedef logic [4:0][31:0] chain_t;

  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] PAD_MARK_WORD = 32'h80000000;

  // Round function group, one per twenty rounds.
  typedef enum logic [1:0] {
    GRP_CH   = 2'd0,
    GRP_PAR1 = 2'd1,
    GRP_MAJ  = 2'd2,
    GRP_PAR2 = 2'd3
  } grp_e;

  // Control of the message buffer and schedule.
  typedef struct packed {
    logic        push;
    logic        step;
    logic        expand;
    logic [31:0] word;
  } sched_ctrl_t;

  // Control of the round unit.
  typedef struct packed {
    logic load;
    logic step;
    grp_e grp;
  } round_ctrl_t;

  function automatic logic [31:0] rotl(logic [31:0] v, logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] round_k(grp_e g);
    logic [31:0] k;
    unique case (g)
      GRP_CH:   k = 32'h5A827999;
      GRP_PAR1: k = 32'h6ED9EBA1;
      GRP_MAJ:  k = 32'h8F1BBCDC;
      GRP_PAR2: k = 32'hCA62C1D6;
      default:  k = 32'h5A827999;
    endcase
    return k;
  endfunction

  // Keeps the valid top bytes of a final word and places the pad byte after them.
  function automatic logic [31:0] pad_word(logic [31:0] data, logic [1:0] cnt);
    logic [31:0] w;
    unique case (cnt)
      2'd0:    w = 32'h80000000;
      2'd1:    w = {data[31:24], 24'h800000};
      2'd2:    w = {data[31:16], 16'h8000};
      2'd3:    w = {data[31:8], 8'h80};
      default: w = 32'h80000000;
    endcase
    return w;
  endfunction

endpackage

/* rtl/sha1md_sched.sv */
// Sixteen-word block buffer and message schedule of the SHA-1 engine.
// Depends on sha1md_pkg; words shift in at the top, the oldest word sits at index 0.
`timescale 1ns / 1ps
module sha1md_sched (
  input  logic                     clk_i,
  input  sha1md_pkg::sched_ctrl_t  ctrl_i,
  output logic [31:0]              wt_o
);
  import sha1md_pkg::*;

  logic [15:0][31:0] w_q;
  logic [15:0][31:0] w_d;
  logic [31:0]       wt;

  // During the first sixteen rounds the block words rotate through; later rounds expand.
  always_comb begin
    if (ctrl_i.expand) begin
      wt = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 5'd1);
    end else begin
      wt = w_q[0];
    end
  end

  // Shift in either a message word or the schedule word of this round.
  always_comb begin
    w_d = w_q;
    if (ctrl_i.push) begin
      w_d = {ctrl_i.word, w_q[15:1]};
    end else if (ctrl_i.step) begin
      w_d = {wt, w_q[15:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign wt_o = wt;

endmodule

/* rtl/sha1md_round.sv */
// Shared SHA-1 round unit: five working registers and one round of logic.
// Depends on sha1md_pkg; one round per enabled cycle, loaded from the chaining words.
`timescale 1ns / 1ps
module sha1md_round (
  input  logic                     clk_i,
  input  sha1md_pkg::round_ctrl_t  ctrl_i,
  input  sha1md_pkg::chain_t       chain_i,
  input  logic [31:0]              wt_i,
  output sha1md_pkg::chain_t       state_o
);
  import sha1md_pkg::*;

  chain_t      v_q;
  chain_t      v_d;
  logic [31:0] f;
  logic [31:0] t;

  // Boolean function of the current group.
  always_comb begin
    unique case (ctrl_i.grp)
      GRP_CH:   f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
      GRP_MAJ:  f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
      GRP_PAR1,
      GRP_PAR2: f = v_q[1] ^ v_q[2] ^ v_q[3];
      default:  f = v_q[1] ^ v_q[2] ^ v_q[3];
    endcase
  end

  assign t = rotl(v_q[0], 5'd5) + f + v_q[4] + round_k(ctrl_i.grp) + wt_i;

  // Load at block start, otherwise advance one round when enabled.
  always_comb begin
    v_d = v_q;
    if (ctrl_i.load) begin
      v_d = chain_i;
    end else if (ctrl_i.step) begin
      v_d = {v_q[3], v_q[2], rotl(v_q[1], 5'd30), v_q[0], t};
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign state_o = v_q;

endmodule

/* rtl/sha1_message_digest.sv */
// SHA-1 message digest engine. A message word is taken while the sequencer is idle; the
// sixteenth word of a block starts the rounds of the shared round unit and then a fold,
// and the next word is not taken until the fold is done. A last word adds one padding
// word per cycle, except while a compression runs, and one or two compressions, then five
// digest words leave one per accepted cycle. Reset (rst_ni low, asynchronous) loads the
// initial hash values and clears the fill position and bit count; the block is ready right after reset.
`timescale 1ns / 1ps
`include "sha1_message_digest_assert.svh"
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] data_word, [34:32] byte_count, rest zero
  input  logic        s_axis_tlast_i,   // last_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast_o    // last_of_digest
);
  import sha1md_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MARK   = 7'b0000010,
    S_ZERO   = 7'b0000100,
    S_LENLO  = 7'b0001000,
    S_ROUND  = 7'b0010000,
    S_FOLD   = 7'b0100000,
    S_DIGEST = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  state_e      ret_q, ret_d;
  state_e      nxt;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] bits_q, bits_d;
  chain_t      h_q, h_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;

  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;
  logic [31:0] wt;
  chain_t      work;
  logic        in_req;
  logic [2:0]  cnt_sat;
  grp_e        grp;

  assign in_req  = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_sat = s_axis_tdata_i[34] ? 3'd4 : s_axis_tdata_i[34:32];

  // Function group from the round counter.
  always_comb begin
    priority if (rnd_q < 7'd20) begin
      grp = GRP_CH;
    end else if (rnd_q < 7'd40) begin
      grp = GRP_PAR1;
    end else if (rnd_q < 7'd60) begin
      grp = GRP_MAJ;
    end else begin
      grp = GRP_PAR2;
    end
  end

  // Sequencer: message intake, padding, compression and digest output.
  always_comb begin
    state_d           = state_q;
    ret_d             = ret_q;
    nxt               = state_q;
    pos_d             = pos_q;
    bits_d            = bits_q;
    h_d               = h_q;
    rnd_d             = rnd_q;
    idx_d             = idx_q;
    sched_ctrl.push   = 1'b0;
    sched_ctrl.step   = 1'b0;
    sched_ctrl.expand = (rnd_q >= 7'd16);
    sched_ctrl.word   = '0;
    round_ctrl.load   = 1'b0;
    round_ctrl.step   = 1'b0;
    round_ctrl.grp    = grp;

    unique case (state_q)
      S_IDLE: begin
        if (in_req) begin
          sched_ctrl.push = 1'b1;
          if (!s_axis_tlast_i) begin
            sched_ctrl.word = s_axis_tdata_i[31:0];
            bits_d          = bits_q + 64'd32;
            nxt             = S_IDLE;
          end else if (cnt_sat == 3'd4) begin
            sched_ctrl.word = s_axis_tdata_i[31:0];
            bits_d          = bits_q + 64'd32;
            nxt             = S_MARK;
          end else begin
            sched_ctrl.word = pad_word(s_axis_tdata_i[31:0], cnt_sat[1:0]);
            bits_d          = bits_q + {58'd0, cnt_sat, 3'd0};
            nxt             = S_ZERO;
          end
        end
      end
      S_MARK: begin
        sched_ctrl.push = 1'b1;
        sched_ctrl.word = PAD_MARK_WORD;
        nxt             = S_ZERO;
      end
      S_ZERO: begin
        // Zeros up to the second to last word, which takes the upper half of the length.
        sched_ctrl.push = 1'b1;
        if (pos_q == 4'd14) begin
          sched_ctrl.word = bits_q[63:32];
          nxt             = S_LENLO;
        end else begin
          sched_ctrl.word = '0;
          nxt             = S_ZERO;
        end
      end
      S_LENLO: begin
        sched_ctrl.push = 1'b1;
        sched_ctrl.word = bits_q[31:0];
        nxt             = S_DIGEST;
      end
      S_ROUND: begin
        sched_ctrl.step = 1'b1;
        round_ctrl.step = 1'b1;
        rnd_d           = rnd_q + 7'd1;
        if (rnd_q == 7'd79) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        for (int i = 0; i < 5; i++) begin
          h_d[i] = h_q[i] + work[i];
        end
        idx_d   = '0;
        state_d = ret_q;
      end
      S_DIGEST: begin
        if (m_axis_tready_i) begin
          if (idx_q == 3'd4) begin
            h_d     = H_INIT;
            bits_d  = '0;
            pos_d   = '0;
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A full buffer starts a compression and resumes where the push was headed.
    if (sched_ctrl.push) begin
      pos_d = pos_q + 4'd1;
      if (pos_q == 4'd15) begin
        ret_d           = nxt;
        state_d         = S_ROUND;
        rnd_d           = '0;
        round_ctrl.load = 1'b1;
      end else begin
        state_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      pos_q   <= '0;
      bits_q  <= '0;
      h_q     <= H_INIT;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pos_q   <= pos_d;
      bits_q  <= bits_d;
      h_q     <= h_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  sha1md_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .wt_o   (wt)
  );

  sha1md_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (round_ctrl),
    .chain_i (h_q),
    .wt_i    (wt),
    .state_o (work)
  );

  // Output side reads the chaining registers directly.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_DIGEST);
  assign m_axis_tdata_o  = {5'd0, idx_q, h_q[idx_q]};
  assign m_axis_tlast_o  = (idx_q == 3'd4);

  `SHA1MD_ASSERT_IMPL(a_ready_excl, s_axis_tready_o, !m_axis_tvalid_o, "ready in digest")
  `SHA1MD_ASSERT_IMPL(a_round_range, state_q == S_ROUND, rnd_q < 7'd80, "round past 79")
  `SHA1MD_ASSERT_IMPL(a_idx_range, m_axis_tvalid_o, idx_q <= 3'd4, "bad digest index")
  `SHA1MD_ASSERT(a_full_compress,
                 (sched_ctrl.push && pos_q == 4'd15) |=> (state_q == S_ROUND),
                 "full block not compressed")
  `SHA1MD_ASSERT(a_fold_after_round,
                 (state_q == S_ROUND && rnd_q == 7'd79) |=> (state_q == S_FOLD),
                 "fold did not follow last round")

endmodule

/* tb/sv/sha1_digest_checker.sv */
// Checker for the SHA-1 message digest block: watches both stream channels,
// keeps its own SHA-1 state to predict each digest and compares every result word.
// Depends on sha1md_pkg for the chaining word type and the initial hash values.
`timescale 1ns / 1ps
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,   // [31:0] data_word, [34:32] byte_count, rest zero
  input  logic        s_tlast_i,   // last_word
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // [31:0] digest_word, [34:32] word_index, rest zero
  input  logic        m_tlast_i,   // last_of_digest
  output int          fail_count_o,
  output int          pending_o
);
  import sha1md_pkg::*;

  localparam logic [31:0] PAD_ONLY_WORD = 32'h8000_0000;
  localparam int          MAX_REPORTS   = 10;

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // Predicted hash state of the message in flight.
  chain_t      chain_q;
  logic [31:0] block_q [16];
  int          fill_bytes_q;
  logic [63:0] msg_bits_q;

  digest_word_t digest_words_q [$];
  int           mismatches;

  function automatic logic [31:0] rot_left(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Eighty rounds over the buffered block, folded into the chaining words.
  task automatic compress_buffered_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, t;
    int r;
    for (r = 0; r < 16; r++) w[r] = block_q[r];
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        wt = rot_left(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
        w[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      t = rot_left(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rot_left(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
    chain_q[4] = chain_q[4] + e;
  endtask

  // Append one word to the block buffer; a full block is compressed at once.
  task automatic absorb_word(input logic [31:0] v);
    block_q[fill_bytes_q / 4] = v;
    fill_bytes_q += 4;
    if (fill_bytes_q >= 64) begin
      compress_buffered_block();
      fill_bytes_q = 0;
    end
  endtask

  task automatic restart_message();
    int i;
    chain_q      = H_INIT;
    fill_bytes_q = 0;
    msg_bits_q   = '0;
    for (i = 0; i < 16; i++) block_q[i] = '0;
  endtask

  // Take one message word; on the last word pad, finish and queue the five digest words.
  task automatic predict_digest(input logic [31:0] data, input logic [2:0] cnt,
                                input logic last);
    int unsigned nbytes;
    logic [31:0] keep;
    digest_word_t dw;
    int i;
    if (!last) begin
      msg_bits_q += 64'd32;
      absorb_word(data);
      return;
    end
    nbytes = (cnt > 3'd4) ? 4 : int'(cnt);
    msg_bits_q += 64'(nbytes * 8);
    if (nbytes == 4) begin
      absorb_word(data);
      absorb_word(PAD_ONLY_WORD);
    end else begin
      keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (8 * (4 - nbytes)));
      absorb_word((data & keep) | (32'h80 << (8 * (3 - nbytes))));
    end
    // The pad byte landed past the length field, so a second final block is needed.
    if (fill_bytes_q > 56) begin
      while (fill_bytes_q != 0) absorb_word(32'h0);
    end
    while (fill_bytes_q < 56) absorb_word(32'h0);
    absorb_word(msg_bits_q[63:32]);
    absorb_word(msg_bits_q[31:0]);
    for (i = 0; i < 5; i++) begin
      dw.digest = chain_q[i];
      dw.index  = 3'(i);
      dw.last   = (i == 4);
      digest_words_q.push_back(dw);
    end
    restart_message();
  endtask

  task automatic check_digest_word();
    digest_word_t want;
    digest_word_t got;
    got.digest = m_tdata_i[31:0];
    got.index  = m_tdata_i[34:32];
    got.last   = m_tlast_i;
    if (digest_words_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected digest word %08h index %0d last %0b", $realtime,
                 got.digest, got.index, got.last);
      return;
    end
    want = digest_words_q.pop_front();
    if (got.digest !== want.digest || got.index !== want.index || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: digest mismatch: expected %08h index %0d last %0b, got %08h index %0d last %0b",
                 $realtime, want.digest, want.index, want.last,
                 got.digest, got.index, got.last);
    end
  endtask

  // Results are compared before the same edge's input request is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_words_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_digest_word();
      if (s_tvalid_i && s_tready_i) predict_digest(s_tdata_i[31:0], s_tdata_i[34:32], s_tlast_i);
      fail_count_o <= mismatches;
      pending_o    <= digest_words_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the SHA-1 message digest testbench: clock, reset, message stimulus, the digest
// receiver and the verdict. Depends on sha1_message_digest and sha1_digest_checker.
`timescale 1ns / 1ps
module tb_top;

  localparam int TIMEOUT_NS  = 2_000_000;
  localparam int END_CYCLES  = 200;
  localparam int HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int pending;

  int items_sent = 0;
  int msg_count  = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int rx_hold_req = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sha1_message_digest u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  sha1_digest_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Offer one message word and hold it until the request is taken.
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic last);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {8'($urandom), 32'($urandom)};
      s_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, cnt, data};
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
    if (last) msg_count++;
  endtask

  // Stop offering and wait until every predicted digest word has been received.
  task automatic drain_digests();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly short messages, some spanning one or two full blocks; last byte count
  // now and then above four.
  task automatic send_random_message();
    int n;
    int i;
    logic [2:0] last_cnt;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 34) : $urandom_range(0, 15);
    for (i = 0; i < n; i++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    last_cnt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
    send_word($urandom, last_cnt, 1'b1);
  endtask

  // Digest receiver: random ready bursts, plus a long hold-off when one is requested.
  initial begin
    int hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int i;
    int rnd_msgs;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages: empty, partial and full last words, oversized byte counts.
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'h6162_63A5, 3'd3, 1'b1);
    send_word(32'hFF00_FF00, 3'd1, 1'b1);
    send_word(32'h00FF_00FF, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    send_word(32'h1234_5678, 3'd7, 1'b1);
    send_word(32'h8765_4321, 3'd5, 1'b1);
    // Pad word lands past the length field: two final blocks; byte counts ignored.
    for (i = 0; i < 13; i++)
      send_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, i[2:0], 1'b0);
    send_word(32'hA5A5_5A5A, 3'd4, 1'b1);
    drain_digests();

    // Random messages with idling on both sides; the sender keeps offering during
    // the long receiver hold-off.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rnd_msgs = 0;
    while (items_sent < 180) begin
      if (rnd_msgs == 2) rx_hold_req = HOLD_CYCLES;
      if (rnd_msgs != 2 && (rnd_msgs == 6 || $urandom_range(0, 9) == 0)) drain_digests();
      send_random_message();
      rnd_msgs++;
    end

    // Closing stretch at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (items_sent < 220) send_random_message();

    drain_digests();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Covered %0d messages in %0d words: empty and partial last words,", msg_count,
             items_sent);
    $display("byte counts above four, one- and two-block padding, stalls on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* sha1_message_digest.f */
+incdir+rtl
rtl/sha1md_pkg.sv
rtl/sha1md_sched.sv
rtl/sha1md_round.sv
rtl/sha1_message_digest.sv
tb/sv/sha1_digest_checker.sv
tb/sv/tb_top.sv
